FILE: hdl/rgd_pkg.sv
package rgd_pkg;

  localparam int TEXT_WORDS = 16;
  localparam int TW_IDX_W   = $clog2(TEXT_WORDS);

  localparam logic [63:0] NAME_FILL = {8{8'h5F}};

  // group type codes, block B [15:12]
  localparam logic [3:0] GT_NAME = 4'h0;
  localparam logic [3:0] GT_TEXT = 4'h2;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_NAME = 2'd1;
  localparam logic [1:0] STAT_TEXT = 2'd2;

  localparam logic [1:0] LAST_PAIR = 2'd3;
  localparam logic [TW_IDX_W-1:0] LAST_WORD = TW_IDX_W'(TEXT_WORDS - 1);

  typedef struct packed {
    logic        operation;
    logic [15:0] group_b;
    logic [15:0] group_c;
    logic [15:0] group_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [63:0]         station_name;
    logic [31:0]         text_word;
    logic [TW_IDX_W-1:0] text_word_index;
    logic                last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic                item_take;
    logic                out_load_item;
    logic                out_load_word;
    logic [TW_IDX_W-1:0] word_idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dump_req;
  } sts_t;

endpackage

FILE: hdl/rgd_datapath.sv
module rgd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rgd_pkg::in_item_t in_data,
  input  rgd_pkg::cmd_t     cmd,
  output rgd_pkg::sts_t     sts,
  output rgd_pkg::out_item_t out_data
);

  logic [63:0] cand_r, cand_nxt;
  logic [63:0] conf_r, conf_nxt;
  logic [63:0] pub_r, pub_nxt;
  logic [rgd_pkg::TEXT_WORDS-1:0] tvalid_r, tvalid_nxt;
  logic        ab_r, ab_nxt;
  logic [31:0] text_r [rgd_pkg::TEXT_WORDS];
  rgd_pkg::out_item_t out_r;

  logic [15:0] blk_b;
  logic        is_clear;
  logic        is_name;
  logic        is_text;
  logic [1:0]  pos;
  logic [5:0]  sh;
  logic [63:0] mask;
  logic [63:0] pair;
  logic [15:0] cand_pair;
  logic        pair_match;
  logic [63:0] conf_upd;
  logic        publish;
  logic [rgd_pkg::TW_IDX_W-1:0] widx;
  logic [1:0]  item_status;

  assign blk_b    = in_data.group_b;
  assign is_clear = in_data.operation == rgd_pkg::OP_CLEAR;
  assign is_name  = !is_clear && blk_b[15:12] == rgd_pkg::GT_NAME;
  assign is_text  = !is_clear && blk_b[15:12] == rgd_pkg::GT_TEXT && !blk_b[11];
  assign pos      = blk_b[1:0];
  // pair 0 sits in the top 16 bits
  assign sh        = {~pos, 4'b0000};
  assign mask      = 64'hFFFF << sh;
  assign pair      = 64'(in_data.group_d) << sh;
  assign cand_pair = 16'(cand_r >> sh);
  assign pair_match = cand_pair == in_data.group_d;
  assign conf_upd   = (conf_r & ~mask) | pair;
  assign publish    = is_name && pair_match && pos == rgd_pkg::LAST_PAIR &&
                      cand_r == conf_upd && conf_upd != pub_r;
  assign widx       = blk_b[rgd_pkg::TW_IDX_W-1:0];

  assign sts.dump_req = is_text && widx == rgd_pkg::LAST_WORD;
  assign item_status  = publish ? rgd_pkg::STAT_NAME : rgd_pkg::STAT_NONE;

  always_comb begin
    cand_nxt   = cand_r;
    conf_nxt   = conf_r;
    pub_nxt    = pub_r;
    tvalid_nxt = tvalid_r;
    ab_nxt     = ab_r;
    if (cmd.item_take) begin
      if (is_clear) begin
        cand_nxt   = rgd_pkg::NAME_FILL;
        conf_nxt   = rgd_pkg::NAME_FILL;
        pub_nxt    = rgd_pkg::NAME_FILL;
        tvalid_nxt = '0;
      end else if (is_name) begin
        if (pair_match) begin
          conf_nxt = conf_upd;
          if (publish) begin
            pub_nxt = conf_upd;
          end
        end else begin
          cand_nxt = (cand_r & ~mask) | pair;
        end
      end else if (is_text) begin
        // a toggled A/B flag starts a new text
        if (blk_b[4] != ab_r) begin
          tvalid_nxt = '0;
        end
        ab_nxt           = blk_b[4];
        tvalid_nxt[widx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r   <= rgd_pkg::NAME_FILL;
      conf_r   <= rgd_pkg::NAME_FILL;
      pub_r    <= rgd_pkg::NAME_FILL;
      tvalid_r <= '0;
      ab_r     <= 1'b0;
    end else begin
      cand_r   <= cand_nxt;
      conf_r   <= conf_nxt;
      pub_r    <= pub_nxt;
      tvalid_r <= tvalid_nxt;
      ab_r     <= ab_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_take && is_text) begin
      text_r[widx] <= {in_data.group_c, in_data.group_d};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_item) begin
      out_r.status          <= item_status;
      out_r.station_name    <= pub_nxt;
      out_r.text_word       <= '0;
      out_r.text_word_index <= '0;
      out_r.last            <= 1'b1;
    end else if (cmd.out_load_word) begin
      out_r.status          <= rgd_pkg::STAT_TEXT;
      out_r.station_name    <= pub_r;
      out_r.text_word       <= tvalid_r[cmd.word_idx] ? text_r[cmd.word_idx] : 32'h0;
      out_r.text_word_index <= cmd.word_idx;
      out_r.last            <= cmd.word_idx == rgd_pkg::LAST_WORD;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/rgd_ctrl.sv
module rgd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rgd_pkg::sts_t sts,
  output rgd_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic state_r, state_nxt;
  logic [rgd_pkg::TW_IDX_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic take;

  // output register empty or emptied this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_DUMP) || !out_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    cmd.item_take     = 1'b0;
    cmd.out_load_item = 1'b0;
    cmd.out_load_word = 1'b0;
    cmd.word_idx      = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd.item_take = 1'b1;
          if (sts.dump_req) begin
            state_nxt = ST_DUMP;
            cnt_nxt   = '0;
          end else begin
            cmd.out_load_item = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          cmd.out_load_word = 1'b1;
          cnt_nxt           = cnt_r + 1'b1;
          if (cnt_r == rgd_pkg::LAST_WORD) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load_item || cmd.out_load_word) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/rds_group_decoder.sv
// RDS group decoder.
// Input channel (in_valid / in_stall / in_data): one word per received RDS
// group (blocks B, C, D) or a clear command. Output channel (out_valid /
// out_stall / out_data): result words, each carrying the published station
// name; the final word of an input has last set.
// A group 0A/0B word, a 2A word other than text word 15, any other group, or
// a clear gives one result, registered in the cycle after the input is taken.
// When text word 15 of a 2A group arrives, the whole 16-word text store is
// emitted as 16 results: the controller enters its dump state, then steps the
// words in order through the output register, one per cycle while the output
// is not stalled.
// Throughput: one input every cycle while single results are taken at once;
// a text dump stalls the input until its last word enters the output register.
// Reset (rst_n low, synchronous) sets all names to underscores, empties the
// text store and the output register.
// A stalled output holds its word; the input is stalled until the output
// register can take the next result.
module rds_group_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rgd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rgd_pkg::out_item_t out_data
);

  rgd_pkg::cmd_t cmd;
  rgd_pkg::sts_t sts;

  rgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rgd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  a_dump_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && sts.dump_req |=> !out_valid)
    else $error("output not empty after text dump start");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rgd_pkg::STAT_TEXT |-> out_data.last)
    else $error("single result without last");

  a_dump_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rgd_pkg::STAT_TEXT && out_data.last
      |-> out_data.text_word_index == rgd_pkg::LAST_WORD)
    else $error("text dump ended early");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load_word |-> in_stall)
    else $error("input taken during text dump");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int  IDLE_LIMIT   = 2000;
  localparam int  HOLD_CYCLES  = 200;
  localparam int  TAIL_CYCLES  = 20;
  localparam int  RANDOM_ITEMS = 420;
  localparam int  SHOWN_ERRORS = 10;
  localparam logic VER_A       = 1'b0;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rgd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  rgd_pkg::out_item_t out_data;

  // decoder state as the testbench tracks it
  logic [63:0] cand_name;
  logic [63:0] conf_name;
  logic [63:0] pub_name;
  logic [31:0] text_words [rgd_pkg::TEXT_WORDS];
  logic        ab_seen;

  rgd_pkg::out_item_t pending_results [$];
  int          mismatches;
  int          idle_cycles;
  int          burst_left;
  logic        stim_ab;
  logic [63:0] name_pool [4];
  logic        hold_req;
  logic        hold_busy;

  rds_group_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rgd_pkg::in_item_t make_word(logic op, logic [15:0] b,
                                                  logic [15:0] c, logic [15:0] d);
    rgd_pkg::in_item_t w;
    w.operation = op;
    w.group_b   = b;
    w.group_c   = c;
    w.group_d   = d;
    return w;
  endfunction

  // Advance the tracked state by one group and queue the results it gives.
  function automatic void decode_group(rgd_pkg::in_item_t w);
    logic [1:0]         stat;
    logic [1:0]         pos;
    int                 shift;
    logic [63:0]        mask;
    logic [63:0]        pair;
    rgd_pkg::out_item_t r;
    stat = rgd_pkg::STAT_NONE;
    if (w.operation == rgd_pkg::OP_CLEAR) begin
      cand_name = rgd_pkg::NAME_FILL;
      conf_name = rgd_pkg::NAME_FILL;
      pub_name  = rgd_pkg::NAME_FILL;
      for (int i = 0; i < rgd_pkg::TEXT_WORDS; i++) text_words[i] = '0;
    end else if (w.group_b[15:12] == rgd_pkg::GT_NAME) begin
      pos   = w.group_b[1:0];
      shift = 48 - 16 * int'(pos);
      mask  = 64'hFFFF << shift;
      pair  = {48'b0, w.group_d} << shift;
      if ((cand_name & mask) == pair) begin
        conf_name = (conf_name & ~mask) | pair;
        if (pos == rgd_pkg::LAST_PAIR && cand_name == conf_name &&
            conf_name != pub_name) begin
          pub_name = conf_name;
          stat     = rgd_pkg::STAT_NAME;
        end
      end else begin
        cand_name = (cand_name & ~mask) | pair;
      end
    end else if (w.group_b[15:12] == rgd_pkg::GT_TEXT && w.group_b[11] == VER_A) begin
      // a toggled A/B flag wipes the whole text first
      if (w.group_b[4] != ab_seen) begin
        ab_seen = w.group_b[4];
        for (int i = 0; i < rgd_pkg::TEXT_WORDS; i++) text_words[i] = '0;
      end
      text_words[w.group_b[3:0]] = {w.group_c, w.group_d};
      if (w.group_b[3:0] == rgd_pkg::LAST_WORD) stat = rgd_pkg::STAT_TEXT;
    end

    if (stat == rgd_pkg::STAT_TEXT) begin
      for (int k = 0; k < rgd_pkg::TEXT_WORDS; k++) begin
        r.status          = rgd_pkg::STAT_TEXT;
        r.station_name    = pub_name;
        r.text_word       = text_words[k];
        r.text_word_index = k[rgd_pkg::TW_IDX_W-1:0];
        r.last            = (k == rgd_pkg::TEXT_WORDS - 1);
        pending_results.push_back(r);
      end
    end else begin
      r.status          = stat;
      r.station_name    = pub_name;
      r.text_word       = '0;
      r.text_word_index = '0;
      r.last            = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void report_mismatch(string what, rgd_pkg::out_item_t want,
                                          rgd_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display({"mismatch (%s): expected st=%0d name=%h word=%h idx=%0d last=%b,",
                " got st=%0d name=%h word=%h idx=%0d last=%b"},
               what, want.status, want.station_name, want.text_word, want.text_word_index,
               want.last, got.status, got.station_name, got.text_word, got.text_word_index,
               got.last);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) decode_group(in_data);
  end

  always @(posedge clk) begin
    rgd_pkg::out_item_t want;
    string              bad;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        want = '0;
        report_mismatch("no result expected", want, out_data);
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (out_data.status != want.status) bad = {bad, " status"};
        if (out_data.station_name != want.station_name) bad = {bad, " station_name"};
        if (out_data.text_word != want.text_word) bad = {bad, " text_word"};
        if (out_data.text_word_index != want.text_word_index) bad = {bad, " text_word_index"};
        if (out_data.last != want.last) bad = {bad, " last"};
        if (bad != "") report_mismatch(bad, want, out_data);
      end
    end
  end

  // watchdog: give up after a long stretch with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    stall_mode_t mode;
    int          run_left;
    int          hold_left;
    int          phase;
    out_stall = 1'b0;
    hold_busy = 1'b0;
    mode      = STALL_NONE;
    run_left  = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_busy) begin
        hold_busy = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_busy) begin
        out_stall <= 1'b1;
        hold_left--;
        if (hold_left == 0) hold_busy = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = stall_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(8, 64);
        end
        run_left--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (phase % 3 == 0);
        endcase
      end
    end
  end

  // Offer one word and hold it until taken; close a burst with a random gap.
  task automatic send_word(rgd_pkg::in_item_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // One name sent pair by pair, one to three times over, with a rare bad pair.
  task automatic send_name_run(output int sent);
    logic [63:0]       name;
    int                slot;
    rgd_pkg::in_item_t w;
    sent = 0;
    slot = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) begin
      name = {$urandom(), $urandom()};
      for (int i = 0; i < 8; i++)
        if ($urandom_range(0, 7) == 0) name[8*i +: 8] = 8'h00;
      name_pool[slot] = name;
    end
    name = name_pool[slot];
    repeat ($urandom_range(1, 3)) begin
      for (int p = 0; p < 4; p++) begin
        w = make_word(rgd_pkg::OP_DECODE, 16'($urandom()), 16'($urandom()),
                      name[63 - 16*p -: 16]);
        w.group_b[15:12] = rgd_pkg::GT_NAME;
        w.group_b[1:0]   = 2'(p);
        if ($urandom_range(0, 19) == 0) w.group_d = 16'($urandom());
        send_word(w);
        sent++;
      end
    end
  endtask

  // A run of text segments ending, most of the time, with the last one.
  task automatic send_text_run(output int sent);
    int                first;
    int                final_word;
    rgd_pkg::in_item_t w;
    sent = 0;
    if ($urandom_range(0, 1) == 0) stim_ab = ~stim_ab;
    first      = ($urandom_range(0, 1) == 0) ? 0
                                             : $urandom_range(0, rgd_pkg::TEXT_WORDS - 1);
    final_word = ($urandom_range(0, 5) == 0) ? $urandom_range(first, rgd_pkg::TEXT_WORDS - 1)
                                             : rgd_pkg::TEXT_WORDS - 1;
    for (int k = first; k <= final_word; k++) begin
      if ($urandom_range(0, 7) == 0) continue;
      w = make_word(rgd_pkg::OP_DECODE, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      w.group_b[15:12] = rgd_pkg::GT_TEXT;
      w.group_b[11]    = VER_A;
      w.group_b[4]     = ($urandom_range(0, 29) == 0) ? ~stim_ab : stim_ab;
      w.group_b[3:0]   = 4'(k);
      send_word(w);
      sent++;
    end
  endtask

  task automatic test_station_name();
    logic [63:0] name;
    name = "NEWS 24 ";
    // first pass loads the candidate, second confirms and publishes
    repeat (2) begin
      for (int p = 0; p < 4; p++)
        send_word(make_word(rgd_pkg::OP_DECODE, {rgd_pkg::GT_NAME, 10'h000, 2'(p)},
                            16'h0000, name[63 - 16*p -: 16]));
    end
    // confirmed again, but already published
    send_word(make_word(rgd_pkg::OP_DECODE,
                        {rgd_pkg::GT_NAME, 10'h000, rgd_pkg::LAST_PAIR},
                        16'hFFFF, name[15:0]));
    send_word(make_word(rgd_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000));
    // version B with zero characters in the last pair
    repeat (2)
      send_word(make_word(rgd_pkg::OP_DECODE,
                          {rgd_pkg::GT_NAME, 10'h200, rgd_pkg::LAST_PAIR},
                          16'h0000, 16'h0000));
  endtask

  task automatic test_radiotext();
    send_word(make_word(rgd_pkg::OP_DECODE, {rgd_pkg::GT_TEXT, 12'h00F}, 16'hFFFF, 16'hFFFF));
    // flag toggles: wipe, then write the first word
    send_word(make_word(rgd_pkg::OP_DECODE, {rgd_pkg::GT_TEXT, 12'h010}, 16'h4142, 16'h4344));
    send_word(make_word(rgd_pkg::OP_DECODE, {rgd_pkg::GT_TEXT, 12'h01F}, 16'h0000, 16'h0000));
    // version B text group: ignored
    send_word(make_word(rgd_pkg::OP_DECODE, {rgd_pkg::GT_TEXT, 12'h81F}, 16'h5A5A, 16'hA5A5));
    stim_ab = 1'b1;
  endtask

  task automatic test_clear_and_other_groups();
    send_word(make_word(rgd_pkg::OP_DECODE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(rgd_pkg::OP_DECODE, 16'h1000, 16'h0000, 16'h0000));
    send_word(make_word(rgd_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  // Hold the receiver off while a full text run and more keep coming.
  task automatic test_backpressure();
    int n;
    hold_req = 1'b1;
    wait (hold_busy);
    hold_req = 1'b0;
    for (int k = 0; k < rgd_pkg::TEXT_WORDS; k++)
      send_word(make_word(rgd_pkg::OP_DECODE, {rgd_pkg::GT_TEXT, 7'h00, stim_ab, 4'(k)},
                          16'($urandom()), 16'($urandom())));
    send_name_run(n);
    wait (!hold_busy);
  endtask

  task automatic test_random_traffic();
    int counted;
    int n;
    int pick;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_name_run(n);
        counted += n;
      end else if (pick < 75) begin
        send_text_run(n);
        counted += n;
      end else if (pick < 80) begin
        send_word(make_word(rgd_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()),
                            16'($urandom())));
        counted++;
      end else begin
        send_word(make_word(rgd_pkg::OP_DECODE, 16'($urandom()), 16'($urandom()),
                            16'($urandom())));
        counted++;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    hold_req   = 1'b0;
    burst_left = 0;
    stim_ab    = 1'b0;
    mismatches = 0;
    cand_name  = rgd_pkg::NAME_FILL;
    conf_name  = rgd_pkg::NAME_FILL;
    pub_name   = rgd_pkg::NAME_FILL;
    ab_seen    = 1'b0;
    for (int i = 0; i < rgd_pkg::TEXT_WORDS; i++) text_words[i] = '0;
    name_pool[0] = "JAZZ FM ";
    name_pool[1] = "CITY 99 ";
    name_pool[2] = 64'h0000_4142_0000_4344;
    name_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_station_name();
    test_radiotext();
    test_clear_and_other_groups();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      $display("%0d expected results never arrived", pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
